@@ hw/rtl/bfa_pkg.sv @@
// Shared types and constants for the best-fit block allocator.
// Used by the allocator's core, controller and datapath; depends on nothing.
package bfa_pkg;

	localparam int BFA_MAX_BLOCKS = 64;
	localparam int BFA_ADDR_BITS  = 16;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_FIT     = 2'd1,
		ST_NOT_FOUND  = 2'd2,
		ST_TABLE_FULL = 2'd3
	} bfa_status_t;

	typedef struct packed {
		logic        command;
		logic [15:0] block_length;
		logic [15:0] block_start;
	} bfa_req_t;

	typedef struct packed {
		logic [15:0] granted_start;
		bfa_status_t status;
	} bfa_rsp_t;

	typedef struct packed {
		logic        load;
		logic        scan;
		logic        up_init;
		logic        up_step;
		logic        dn_init;
		logic        dn_step;
		logic        insert;
		logic        remove;
		logic        reply;
		bfa_status_t code;
	} bfa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic full;
		logic found;
		logic scan_last;
		logic up_done;
		logic dn_done;
	} bfa_sts_t;

endpackage

@@ hw/rtl/best_fit_block_allocator_core.sv @@
// Best-fit block allocator, top level: controller plus datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_dpath (and through it bfa_ram).
//
// Usage: drive request and pulse start while busy is low; the beat is taken
// at that edge and busy rises in the next cycle. Each request yields one
// result beat: done is high for exactly one cycle with result valid, and
// the receiver cannot hold it off. busy is low again in that cycle, so a
// new request can be taken at the same edge that takes the result.
// A request walks the table once through the single RAM read port, then
// decides and replies. A granted allocate then moves the blocks above the
// new one up by one entry, one per cycle; a successful free moves the
// blocks above the freed one down the same way. The table RAM has one
// read and one write port. The user must write pool_size through
// cfg_valid/cfg_ready (always ready) only while the block is idle; the
// block itself does not enforce this. Reset empties the table and sets
// pool_size to 65535; the table RAM itself is not cleared and needs no
// clearing pass.
module best_fit_block_allocator_core #(
	parameter int MAX_BLOCKS = bfa_pkg::BFA_MAX_BLOCKS,
	parameter int ADDR_BITS  = bfa_pkg::BFA_ADDR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bfa_pkg::bfa_req_t request,
	output logic              done,
	output bfa_pkg::bfa_rsp_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);
	import bfa_pkg::*;

	bfa_cmd_t cmd;
	bfa_sts_t sts;

	bfa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	bfa_dpath #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.ADDR_BITS (ADDR_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a request in flight");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted request");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result beat right after accept");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.granted_start == 16'd0))
		else $error("nonzero address on failed request");

endmodule

@@ hw/rtl/bfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/bfa_ctrl.sv @@
// Sequencing state machine of the allocator: scan, decide, shift, reply.
// Depends on bfa_pkg for the command and status structs.
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bfa_pkg::bfa_sts_t sts,
	output bfa_pkg::bfa_cmd_t cmd
);
	import bfa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DRAIN  = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_UP     = 8'b0001_0000,
		S_INSERT = 8'b0010_0000,
		S_DOWN   = 8'b0100_0000,
		S_REMOVE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!sts.is_free && sts.full) begin
					cmd.reply = 1'b1;
					cmd.code  = ST_TABLE_FULL;
					state_d   = S_IDLE;
				end else if (!sts.found) begin
					cmd.reply = 1'b1;
					cmd.code  = sts.is_free ? ST_NOT_FOUND : ST_NO_FIT;
					state_d   = S_IDLE;
				end else if (sts.is_free) begin
					cmd.dn_init = 1'b1;
					state_d     = S_DOWN;
				end else begin
					cmd.up_init = 1'b1;
					state_d     = S_UP;
				end
			end
			S_UP: begin
				cmd.up_step = 1'b1;
				if (sts.up_done) begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				cmd.reply  = 1'b1;
				cmd.code   = ST_OK;
				state_d    = S_IDLE;
			end
			S_DOWN: begin
				cmd.dn_step = 1'b1;
				if (sts.dn_done) begin
					state_d = S_REMOVE;
				end
			end
			S_REMOVE: begin
				cmd.remove = 1'b1;
				cmd.reply  = 1'b1;
				cmd.code   = ST_OK;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/bfa_dpath.sv @@
// Datapath of the allocator: block table RAM, gap evaluation, shift pipe,
// pool size register and result register. Depends on bfa_pkg and bfa_ram.
module bfa_dpath #(
	parameter int MAX_BLOCKS = bfa_pkg::BFA_MAX_BLOCKS,
	parameter int ADDR_BITS  = bfa_pkg::BFA_ADDR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfa_pkg::bfa_req_t request,
	input  bfa_pkg::bfa_cmd_t cmd,
	output bfa_pkg::bfa_sts_t sts,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data,
	output logic              done,
	output bfa_pkg::bfa_rsp_t result
);
	import bfa_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int AW = ADDR_BITS;
	localparam int EW = 2 * AW;

	logic          cmd_q;
	logic [AW-1:0] len_q, start_q, pool_q;
	logic [CW-1:0] count_q, ri_q, pos_q;
	logic          found_q;
	logic [AW-1:0] best_size_q, best_addr_q;
	logic [AW:0]   prev_end_q;

	logic          scan_v_s1, last_s1, up_v_s1, dn_v_s1;
	logic [CW-1:0] idx_s1;

	logic          done_q;
	bfa_rsp_t      rsp_q;

	logic [CW-1:0] ri_m1, ri_p1, idx_p1, idx_m1;
	logic [IW-1:0] raddr, waddr;
	logic [EW-1:0] rdata, wdata;
	logic          we;
	logic [AW-1:0] rd_start, rd_len, hi, gap_size;
	logic [AW:0]   gap_w, end_w;
	logic          gap_ok, fit, match;
	logic          up_go, dn_go;

	assign ri_m1  = ri_q - CW'(1);
	assign ri_p1  = ri_q + CW'(1);
	assign idx_p1 = idx_s1 + CW'(1);
	assign idx_m1 = idx_s1 - CW'(1);

	assign sts.is_free   = (cmd_q == CMD_FREE);
	assign sts.full      = (count_q == CW'(MAX_BLOCKS));
	assign sts.found     = found_q;
	assign sts.scan_last = (ri_q == count_q);
	assign sts.up_done   = (ri_q == pos_q);
	assign sts.dn_done   = (ri_q == count_q);

	assign up_go = cmd.up_step && !sts.up_done;
	assign dn_go = cmd.dn_step && !sts.dn_done;

	assign raddr = cmd.up_step ? ri_m1[IW-1:0] : ri_q[IW-1:0];

	assign rd_start = rdata[EW-1:AW];
	assign rd_len   = rdata[AW-1:0];
	assign hi       = last_s1 ? pool_q : rd_start;
	assign gap_ok   = ({1'b0, hi} >= prev_end_q);
	assign gap_w    = {1'b0, hi} - prev_end_q;
	assign gap_size = gap_w[AW-1:0];
	assign fit      = gap_ok && (len_q <= gap_size) && (!found_q || gap_size < best_size_q);
	assign match    = !last_s1 && !found_q && (rd_start == start_q) && (rd_len == len_q);
	assign end_w    = {1'b0, rd_start} + {1'b0, rd_len};

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[IW-1:0];
		wdata = rdata;
		if (up_v_s1) begin
			we    = 1'b1;
			waddr = idx_p1[IW-1:0];
		end else if (dn_v_s1) begin
			we    = 1'b1;
			waddr = idx_m1[IW-1:0];
		end else if (cmd.insert) begin
			we    = 1'b1;
			wdata = {best_addr_q, len_q};
		end
	end

	bfa_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q    <= AW'(16'hFFFF);
			count_q   <= '0;
			ri_q      <= '0;
			found_q   <= 1'b0;
			scan_v_s1 <= 1'b0;
			up_v_s1   <= 1'b0;
			dn_v_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_q <= AW'(cfg_data);
			end
			scan_v_s1 <= cmd.scan;
			up_v_s1   <= up_go;
			dn_v_s1   <= dn_go;
			done_q    <= cmd.reply;

			if (cmd.load) begin
				ri_q    <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan && !sts.scan_last) begin
				ri_q <= ri_p1;
			end else if (cmd.up_init) begin
				ri_q <= count_q;
			end else if (up_go) begin
				ri_q <= ri_m1;
			end else if (cmd.dn_init) begin
				ri_q <= pos_q + CW'(1);
			end else if (dn_go) begin
				ri_q <= ri_p1;
			end

			if (scan_v_s1) begin
				if (cmd_q == CMD_ALLOC) begin
					if (fit) begin
						found_q <= 1'b1;
					end
				end else if (match) begin
					found_q <= 1'b1;
				end
			end

			if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.remove) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= request.command;
			len_q      <= AW'(request.block_length);
			start_q    <= AW'(request.block_start);
			prev_end_q <= '0;
		end
		last_s1 <= sts.scan_last;
		idx_s1  <= cmd.up_step ? ri_m1 : ri_q;
		if (scan_v_s1) begin
			if (cmd_q == CMD_ALLOC) begin
				if (fit) begin
					best_size_q <= gap_size;
					best_addr_q <= prev_end_q[AW-1:0];
					pos_q       <= idx_s1;
				end
				prev_end_q <= end_w;
			end else if (match) begin
				pos_q <= idx_s1;
			end
		end
		if (cmd.reply) begin
			rsp_q.status        <= cmd.code;
			rsp_q.granted_start <= cmd.insert ? 16'(best_addr_q) : 16'd0;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule
